>>> rtl/rlps_pkg.sv
// rlps_pkg: shared types, constants and the arctangent table for the pursuit steering block
// no dependencies; imported by every module under rtl

package rlps_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int X_W          = 28;
    localparam int ACC_W        = 32;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [2:0] REG_TURN_RATE    = 3'd0;
    localparam logic [2:0] REG_FAR_DIST_SQ  = 3'd1;
    localparam logic [2:0] REG_NEAR_DIST_SQ = 3'd2;
    localparam logic [2:0] REG_FAST_SPEED   = 3'd3;
    localparam logic [2:0] REG_SLOW_SPEED   = 3'd4;

    localparam logic [1:0] BAND_STOP = 2'd0;
    localparam logic [1:0] BAND_SLOW = 2'd1;
    localparam logic [1:0] BAND_FAST = 2'd2;

    localparam logic [15:0] TURN_RATE_RST    = 16'd16384;
    localparam logic [47:0] FAR_DIST_SQ_RST  = 48'd1638400;
    localparam logic [47:0] NEAR_DIST_SQ_RST = 48'd409600;
    localparam logic [15:0] FAST_SPEED_RST   = 16'd1024;
    localparam logic [15:0] SLOW_SPEED_RST   = 16'd256;

    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ROUND_HALF = 32'h0000_8000;

    // rounded atan(2^-i), one turn = 2^32
    localparam logic [ACC_W-1:0] ATAN_TAB [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [15:0] turn_rate;
        logic [47:0] far_dist_sq;
        logic [47:0] near_dist_sq;
        logic [15:0] fast_speed;
        logic [15:0] slow_speed;
    } cfg_t;

    typedef struct packed {
        logic [15:0] lim;
        logic        zero;
        logic [15:0] speed;
        logic [1:0]  speed_band;
    } side_t;

    typedef struct packed {
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        side_t              side;
    } front_t;

    typedef struct packed {
        logic [15:0] bearing;
        side_t       side;
    } qent_t;

endpackage

>>> rtl/rate_limited_pursuit_steering.sv
// rate_limited_pursuit_steering: top level; configuration registers and the
// front, cordic, queue and heading stages. depends on rlps_pkg and the rlps_* modules
//
// usage:
//   item channel (item_valid/item_ready) takes one frame beat: follower and
//   target positions plus the frame time. result channel (result_valid/
//   result_ready) returns one beat per item: new heading, speed, speed band.
//   registers are written through wr_en/wr_index/wr_data; the user must write them
//   only while the block is idle, which the block itself does not enforce. an index
//   beyond the last register is dropped.
// pipeline: 4 front stages, 17 cordic stages, then the queue and the result register.
// throughput: one beat per cycle while result_ready is high. the bearing and distance
//   paths are fully pipelined; the only loop is the heading add-and-clamp.
// stall: when result_ready is low the 4-entry queue fills, then the front and
//   cordic stages hold and item_ready drops until space opens again.
// reset: all registers return to their default values, the heading to zero,
//   and the pipeline and queue empty.

module rate_limited_pursuit_steering (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [47:0]         wr_data,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic signed [23:0]  own_x,
    input  logic signed [23:0]  own_y,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  logic [15:0]         frame_time,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [15:0]         heading,
    output logic [15:0]         speed,
    output logic [1:0]          speed_band
);
    import rlps_pkg::*;

    cfg_t    cfg_reg;
    logic    en;
    logic    front_valid;
    front_t  front_item;
    logic    entry_valid;
    qent_t   entry;
    logic    q_full, q_valid, q_pop;
    qent_t   q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_rate    <= TURN_RATE_RST;
            cfg_reg.far_dist_sq  <= FAR_DIST_SQ_RST;
            cfg_reg.near_dist_sq <= NEAR_DIST_SQ_RST;
            cfg_reg.fast_speed   <= FAST_SPEED_RST;
            cfg_reg.slow_speed   <= SLOW_SPEED_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_TURN_RATE:    cfg_reg.turn_rate    <= wr_data[15:0];
                REG_FAR_DIST_SQ:  cfg_reg.far_dist_sq  <= wr_data;
                REG_NEAR_DIST_SQ: cfg_reg.near_dist_sq <= wr_data;
                REG_FAST_SPEED:   cfg_reg.fast_speed   <= wr_data[15:0];
                REG_SLOW_SPEED:   cfg_reg.slow_speed   <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    // the front and cordic pipelines move as a whole while the queue has room
    assign en         = !q_full;
    assign item_ready = en;

    rlps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .item_valid  (item_valid),
        .own_x       (own_x),
        .own_y       (own_y),
        .target_x    (target_x),
        .target_y    (target_y),
        .frame_time  (frame_time),
        .cfg         (cfg_reg),
        .front_valid (front_valid),
        .front_item  (front_item)
    );

    rlps_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .front_valid (front_valid),
        .front_item  (front_item),
        .entry_valid (entry_valid),
        .entry       (entry)
    );

    rlps_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (en && entry_valid),
        .wdata  (entry),
        .full   (q_full),
        .pop    (q_pop),
        .rvalid (q_valid),
        .rdata  (q_data)
    );

    rlps_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .heading      (heading),
        .speed        (speed),
        .speed_band   (speed_band)
    );

endmodule

>>> rtl/rlps_front.sv
// rlps_front: input stages; position deltas, turn limit, squared distance and speed band
// depends on rlps_pkg

module rlps_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                item_valid,
    input  logic signed [23:0]  own_x,
    input  logic signed [23:0]  own_y,
    input  logic signed [23:0]  target_x,
    input  logic signed [23:0]  target_y,
    input  logic [15:0]         frame_time,
    input  rlps_pkg::cfg_t      cfg,
    output logic                front_valid,
    output rlps_pkg::front_t    front_item
);
    import rlps_pkg::*;

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [24:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, dx3_reg, dy3_reg;
    logic [15:0]        lim1_reg, lim2_reg, lim3_reg;
    logic [47:0]        sqx2_reg, sqy2_reg;
    logic [48:0]        dsq3_reg;
    front_t             item4_reg;

    logic [31:0]        lim_prod;
    logic signed [49:0] sqx_full, sqy_full;
    logic               gt_far, gt_near;
    front_t             item4_next;

    assign lim_prod = 32'(cfg.turn_rate) * 32'(frame_time);
    assign sqx_full = dx1_reg * dx1_reg;
    assign sqy_full = dy1_reg * dy1_reg;
    assign gt_far   = dsq3_reg > {1'b0, cfg.far_dist_sq};
    assign gt_near  = dsq3_reg > {1'b0, cfg.near_dist_sq};

    always_comb
    begin
        item4_next.dx          = dx3_reg;
        item4_next.dy          = dy3_reg;
        item4_next.side.lim    = lim3_reg;
        item4_next.side.zero   = (dx3_reg == '0) && (dy3_reg == '0);
        item4_next.side.speed  = '0;
        item4_next.side.speed_band = BAND_STOP;
        if (gt_far)
        begin
            item4_next.side.speed      = cfg.fast_speed;
            item4_next.side.speed_band = BAND_FAST;
        end
        else if (gt_near)
        begin
            item4_next.side.speed      = cfg.slow_speed;
            item4_next.side.speed_band = BAND_SLOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= item_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx1_reg   <= 25'(target_x) - 25'(own_x);
            dy1_reg   <= 25'(target_y) - 25'(own_y);
            lim1_reg  <= lim_prod[31:16];
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
            lim2_reg  <= lim1_reg;
            sqx2_reg  <= sqx_full[47:0];
            sqy2_reg  <= sqy_full[47:0];
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;
            lim3_reg  <= lim2_reg;
            dsq3_reg  <= 49'(sqx2_reg) + 49'(sqy2_reg);
            item4_reg <= item4_next;
        end
    end

    assign front_valid = v4_reg;
    assign front_item  = item4_reg;

endmodule

>>> rtl/rlps_cordic.sv
// rlps_cordic: pipelined cordic vectoring, one rotation per stage, gives the bearing
// depends on rlps_pkg

module rlps_cordic (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              front_valid,
    input  rlps_pkg::front_t  front_item,
    output logic              entry_valid,
    output rlps_pkg::qent_t   entry
);
    import rlps_pkg::*;

    logic                    v_reg   [0:CORDIC_STEPS];
    logic signed [X_W-1:0]   x_reg   [0:CORDIC_STEPS];
    logic signed [X_W-1:0]   y_reg   [0:CORDIC_STEPS];
    logic [ACC_W-1:0]        acc_reg [0:CORDIC_STEPS];
    side_t                   side_reg[0:CORDIC_STEPS];

    logic [ACC_W-1:0]        acc_round;

    // fold the left half-plane over before the first rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= front_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= front_item.side;
            if (front_item.dy > 0)
            begin
                x_reg[0]   <= X_W'(front_item.dy);
                y_reg[0]   <= -X_W'(front_item.dx);
                acc_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0]   <= -X_W'(front_item.dy);
                y_reg[0]   <= X_W'(front_item.dx);
                acc_reg[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_step
        logic signed [X_W-1:0] xs, ys;

        assign xs = x_reg[g] >>> g;
        assign ys = y_reg[g] >>> g;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[g+1] <= 1'b0;
            else if (en)
                v_reg[g+1] <= v_reg[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[g+1] <= side_reg[g];
                if (y_reg[g] > 0)
                begin
                    x_reg[g+1]   <= x_reg[g] + ys;
                    y_reg[g+1]   <= y_reg[g] - xs;
                    acc_reg[g+1] <= acc_reg[g] + ATAN_TAB[g];
                end
                else if (y_reg[g] < 0)
                begin
                    x_reg[g+1]   <= x_reg[g] - ys;
                    y_reg[g+1]   <= y_reg[g] + xs;
                    acc_reg[g+1] <= acc_reg[g] - ATAN_TAB[g];
                end
                else
                begin
                    x_reg[g+1]   <= x_reg[g];
                    y_reg[g+1]   <= y_reg[g];
                    acc_reg[g+1] <= acc_reg[g];
                end
            end
        end
    end

    assign acc_round     = acc_reg[CORDIC_STEPS] + ROUND_HALF;
    assign entry_valid   = v_reg[CORDIC_STEPS];
    assign entry.bearing = acc_round[ACC_W-1:ACC_W-16];
    assign entry.side    = side_reg[CORDIC_STEPS];

endmodule

>>> rtl/rlps_queue.sv
// rlps_queue: small fifo that decouples the bearing pipeline from the heading update
// depends on rlps_pkg

module rlps_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rlps_pkg::qent_t  wdata,
    output logic             full,
    input  logic             pop,
    output logic             rvalid,
    output rlps_pkg::qent_t  rdata
);
    import rlps_pkg::*;

    qent_t              mem [0:QDEPTH-1];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign full   = (count_reg == QCNT_W'(QDEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem[rd_ptr_reg];

endmodule

>>> rtl/rlps_back.sv
// rlps_back: heading update loop with the rate-limited turn, and the result register
// depends on rlps_pkg

module rlps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  rlps_pkg::qent_t  q_data,
    output logic             q_pop,
    output logic             result_valid,
    input  logic             result_ready,
    output logic [15:0]      heading,
    output logic [15:0]      speed,
    output logic [1:0]       speed_band
);
    import rlps_pkg::*;

    logic               out_valid_reg;
    logic [15:0]        heading_reg, heading_next;
    logic [15:0]        out_heading_reg, out_speed_reg;
    logic [1:0]         out_band_reg;

    logic [15:0]        ediff;
    logic signed [16:0] err, neg_err, lim_s, step;

    assign q_pop   = q_valid && (!out_valid_reg || result_ready);
    assign ediff   = q_data.bearing - heading_reg;
    assign err     = {ediff[15], ediff};
    assign neg_err = -err;
    assign lim_s   = {1'b0, q_data.side.lim};

    // half a turn of error reads negative, so that case turns the negative way
    always_comb
    begin
        if (err > lim_s)
            step = lim_s;
        else if (neg_err > lim_s)
            step = -lim_s;
        else
            step = err;
        heading_next = heading_reg;
        if (!q_data.side.zero)
            heading_next = heading_reg + step[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            heading_reg   <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
                heading_reg   <= heading_next;
            end
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_heading_reg <= heading_next;
            out_speed_reg   <= q_data.side.speed;
            out_band_reg    <= q_data.side.speed_band;
        end
    end

    assign result_valid = out_valid_reg;
    assign heading      = out_heading_reg;
    assign speed        = out_speed_reg;
    assign speed_band   = out_band_reg;

endmodule

>>> tb/rate_limited_pursuit_steering_tb.sv
// rate_limited_pursuit_steering_tb: self-checking bench for the pursuit steering block.
// a bit-exact heading/speed predictor, or the typed expectation of a directed row, checks every result beat.
// depends on rlps_pkg and rtl/rate_limited_pursuit_steering.sv
`timescale 1ns / 1ps

module rate_limited_pursuit_steering_tb;

    import rlps_pkg::*;

    localparam int CLK_HALF    = 2;
    localparam int ITERS       = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 240;
    localparam int TAIL_CYCLES = 30;
    localparam int CYCLE_LIMIT = 1000000;

    // rounded atan(2^-i), one turn = 2^32
    localparam logic [31:0] ARCTAN [0:ITERS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef struct packed {
        logic signed [23:0] own_x;
        logic signed [23:0] own_y;
        logic signed [23:0] tgt_x;
        logic signed [23:0] tgt_y;
        logic [15:0]        ft;
    } frame_t;

    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] speed;
        logic [1:0]  band;
    } steer_t;

    typedef struct {
        frame_t frame;
        bit     typed;
        steer_t want;
    } vector_t;

    // rows with typed results run from reset, where the heading is still zero
    vector_t directed [21] = '{
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd0, 16'd0}, 1'b1, '{16'd0, 16'd0, BAND_STOP}},
        '{'{24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16'hFFFF}, 1'b1,
          '{16'd0, 16'd0, BAND_STOP}},
        '{'{24'sd0, 24'sd0, 24'sd0, -24'sd2560, 16'hFFFF}, 1'b1,
          '{16'd0, 16'd1024, BAND_FAST}},
        // exactly on the far threshold, exactly on the near threshold
        '{'{24'sd0, 24'sd0, 24'sd0, -24'sd1280, 16'd100}, 1'b1,
          '{16'd0, 16'd256, BAND_SLOW}},
        '{'{24'sd0, 24'sd0, 24'sd0, -24'sd640, 16'hFFFF}, 1'b1,
          '{16'd0, 16'd0, BAND_STOP}},
        '{'{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 16'd0}, 1'b1,
          '{16'd0, 16'd1024, BAND_FAST}},
        // target straight behind: half-turn error turns negative
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd2560, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sd2560, 16'hFFFF}, 1'b0, '0},
        '{'{24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 16'h8000}, 1'b0, '0},
        '{'{24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 16'hFFFF}, 1'b0, '0},
        '{'{24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sd256, 24'sd0, 16'h4000}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, -24'sd256, 24'sd0, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd100, 24'sd100, 24'sd101, 24'sd100, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd100, 24'sd100, 24'sd100, 24'sd101, 16'hFFFF}, 1'b0, '0},
        '{'{-24'sd5000, 24'sd3000, -24'sd4999, 24'sd2999, 16'hFFFF}, 1'b0, '0},
        // same spot after turning: heading must hold
        '{'{24'sd5, 24'sd5, 24'sd5, 24'sd5, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd12345, -24'sd6789, -24'sd2345, 24'sd40000, 16'd1234}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sh7FFFFF, 24'sd0, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sh800000, 24'sh800000, 16'hFFFF}, 1'b0, '0},
        '{'{24'sd0, 24'sd0, 24'sd0, 24'sh800000, 16'hFFFF}, 1'b0, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               wr_en;
    logic [2:0]         wr_index;
    logic [47:0]        wr_data;
    logic               item_valid;
    logic               item_ready;
    logic signed [23:0] own_x;
    logic signed [23:0] own_y;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic [15:0]        frame_time;
    logic               result_valid;
    logic               result_ready;
    logic [15:0]        heading;
    logic [15:0]        speed;
    logic [1:0]         speed_band;

    // predictor copy of the block state and registers
    logic [15:0] cur_heading;
    logic [15:0] cfg_turn;
    logic [47:0] cfg_far;
    logic [47:0] cfg_near;
    logic [15:0] cfg_fast;
    logic [15:0] cfg_slow;
    int          far_root;
    int          near_root;
    bit          calm;

    steer_t      pending [$];
    int          mismatches;
    int          checked;
    int          accepted;
    longint      cycles;

    rate_limited_pursuit_steering u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .own_x        (own_x),
        .own_y        (own_y),
        .target_x     (target_x),
        .target_y     (target_y),
        .frame_time   (frame_time),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .heading      (heading),
        .speed        (speed),
        .speed_band   (speed_band)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    function automatic logic [15:0] bearing_of(longint dx, longint dy);
        longint      xv;
        longint      yv;
        longint      xs;
        longint      ys;
        logic [31:0] acc;
        xv  = -dy;
        yv  = dx;
        acc = '0;
        if (xv < 0)
        begin
            xv  = -xv;
            yv  = -yv;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv > 0)
            begin
                xv  = xv + ys;
                yv  = yv - xs;
                acc = acc + ARCTAN[i];
            end
            else if (yv < 0)
            begin
                xv  = xv - ys;
                yv  = yv + xs;
                acc = acc - ARCTAN[i];
            end
        end
        acc = acc + 32'h0000_8000;
        return acc[31:16];
    endfunction

    // advances the predicted heading and returns the result beat for one frame
    function automatic steer_t steer_step(frame_t f);
        longint      dx;
        longint      dy;
        longint      lim;
        logic [63:0] dsq;
        logic [15:0] ediff;
        int          err;
        int          turn;
        steer_t      r;
        dx  = longint'(f.tgt_x) - longint'(f.own_x);
        dy  = longint'(f.tgt_y) - longint'(f.own_y);
        dsq = dx * dx + dy * dy;
        if (dx != 0 || dy != 0)
        begin
            ediff = bearing_of(dx, dy) - cur_heading;
            err   = $signed(ediff);
            lim   = (longint'(cfg_turn) * longint'(f.ft)) >> 16;
            turn  = 0;
            if (err > 0)
                turn = (err > lim) ? int'(lim) : err;
            else if (err < 0)
                turn = (-err > lim) ? -int'(lim) : err;
            cur_heading = cur_heading + turn[15:0];
        end
        r.heading = cur_heading;
        if (dsq > {16'd0, cfg_far})
        begin
            r.speed = cfg_fast;
            r.band  = BAND_FAST;
        end
        else if (dsq > {16'd0, cfg_near})
        begin
            r.speed = cfg_slow;
            r.band  = BAND_SLOW;
        end
        else
        begin
            r.speed = '0;
            r.band  = BAND_STOP;
        end
        return r;
    endfunction

    function automatic int spread(int mag);
        return int'($urandom_range(0, 2 * mag)) - mag;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     kind;
        int     span;
        int     ox;
        int     oy;
        int     dx;
        int     dy;
        int     root;
        kind = $urandom_range(0, 99);
        span = 2 * (far_root + near_root) + 64;
        if (span > 4000000)
            span = 4000000;
        ox = spread(4000000);
        oy = spread(4000000);
        dx = spread(span);
        dy = spread(span);
        if (kind < 8)
        begin
            dx = 0;
            dy = 0;
        end
        else if (kind < 20)
        begin
            // on a threshold or one step either side of it
            root = ($urandom_range(0, 1) ? far_root : near_root) + spread(1);
            if ($urandom_range(0, 1))
            begin
                dx = 0;
                dy = $urandom_range(0, 1) ? root : -root;
            end
            else
            begin
                dy = 0;
                dx = $urandom_range(0, 1) ? root : -root;
            end
        end
        else if (kind < 28)
        begin
            if ($urandom_range(0, 1))
                dx = 0;
            else
                dy = 0;
        end
        else if (kind < 34)
            dy = $urandom_range(0, 1) ? dx : -dx;
        f.own_x = ox;
        f.own_y = oy;
        f.tgt_x = ox + dx;
        f.tgt_y = oy + dy;
        if (kind >= 70)
        begin
            f.own_x = $urandom;
            f.own_y = $urandom;
            f.tgt_x = $urandom;
            f.tgt_y = $urandom;
        end
        kind = $urandom_range(0, 99);
        if (kind < 12)
            f.ft = '0;
        else if (kind < 27)
            f.ft = 16'hFFFF;
        else if (kind < 55)
            f.ft = $urandom_range(0, 2047);
        else
            f.ft = $urandom;
        return f;
    endfunction

    task automatic send_frame(frame_t f, bit typed, steer_t want);
        int     gap;
        steer_t predicted;
        gap = idle_len();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        own_x      <= f.own_x;
        own_y      <= f.own_y;
        target_x   <= f.tgt_x;
        target_y   <= f.tgt_y;
        frame_time <= f.ft;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        predicted = steer_step(f);
        pending.push_back(typed ? want : predicted);
        accepted++;
    endtask

    // drop valid and hold the sender until every expected beat is back
    task automatic wait_results(int tail);
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending.size() != 0);
        repeat (tail) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(posedge clk);
        case (idx)
            REG_TURN_RATE:    cfg_turn = val[15:0];
            REG_FAR_DIST_SQ:  cfg_far  = val;
            REG_NEAR_DIST_SQ: cfg_near = val;
            REG_FAST_SPEED:   cfg_fast = val[15:0];
            REG_SLOW_SPEED:   cfg_slow = val[15:0];
            default: ;
        endcase
    endtask

    task automatic report_field(string name, int want, int got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    endtask

    // result side: random stalls, none in calm phases
    initial
    begin
        int ready_run;
        int ready_gap;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            ready_run = calm ? 50 : $urandom_range(1, 12);
            result_ready <= 1'b1;
            repeat (ready_run) @(posedge clk);
            ready_gap = idle_len();
            if (ready_gap > 0)
            begin
                result_ready <= 1'b0;
                repeat (ready_gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        steer_t want;
        steer_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got = '{heading, speed, speed_band};
            if (pending.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with none expected, heading %0d speed %0d band %0d",
                         $time, got.heading, got.speed, got.band);
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (got.heading !== want.heading)
                    report_field("heading", want.heading, got.heading);
                if (got.speed !== want.speed)
                    report_field("speed", want.speed, got.speed);
                if (got.band !== want.band)
                    report_field("speed_band", want.band, got.band);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d beats outstanding", cycles, pending.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] turn_val;
        logic [15:0] fast_val;
        logic [15:0] slow_val;
        logic [47:0] far_val;
        logic [47:0] near_val;
        bit          square_thr;
        int          pause_at;

        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        item_valid   = 1'b0;
        own_x        = '0;
        own_y        = '0;
        target_x     = '0;
        target_y     = '0;
        frame_time   = '0;
        result_ready = 1'b0;
        calm         = 1'b0;
        cur_heading  = '0;
        cfg_turn     = 16'd16384;
        cfg_far      = 48'd1638400;
        cfg_near     = 48'd409600;
        cfg_fast     = 16'd1024;
        cfg_slow     = 16'd256;
        far_root     = 1280;
        near_root    = 640;
        mismatches   = 0;
        checked      = 0;
        accepted     = 0;
        cycles       = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_frame(directed[i].frame, directed[i].typed, directed[i].want);
        wait_results(TAIL_CYCLES);

        for (int p = 0; p < PHASES; p++)
        begin
            calm       = (p == 1 || p == 5);
            square_thr = 1'b1;
            turn_val   = 16'd16384;
            fast_val   = 16'd1024;
            slow_val   = 16'd256;
            far_root   = 1280;
            near_root  = 640;
            case (p)
                1:
                begin
                    turn_val  = 16'hFFFF;
                    far_root  = 0;
                    near_root = 0;
                    fast_val  = 16'hFFFF;
                    slow_val  = '0;
                end
                2:
                begin
                    // only the widest distances clear an all-ones threshold
                    square_thr = 1'b0;
                    far_val    = '1;
                    near_val   = '1;
                    turn_val   = '0;
                    far_root   = 3000;
                    near_root  = 1000;
                    fast_val   = $urandom;
                    slow_val   = $urandom;
                end
                3:
                begin
                    // near above far: fast test wins
                    turn_val  = $urandom;
                    far_root  = $urandom_range(64, 4000);
                    near_root = far_root + $urandom_range(1, 4000);
                    fast_val  = $urandom;
                    slow_val  = $urandom;
                end
                4:
                begin
                    turn_val  = $urandom_range(0, 512);
                    near_root = $urandom_range(0, 20000);
                    far_root  = near_root + $urandom_range(0, 20000);
                end
                5:
                begin
                    turn_val  = $urandom;
                    near_root = $urandom_range(0, 500000);
                    far_root  = near_root + $urandom_range(0, 500000);
                    fast_val  = $urandom;
                    slow_val  = $urandom;
                end
                6:
                begin
                    square_thr = 1'b0;
                    far_val    = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
                    near_val   = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
                    far_root   = $urandom_range(0, 100000);
                    near_root  = $urandom_range(0, 100000);
                    turn_val   = $urandom;
                    fast_val   = $urandom;
                    slow_val   = $urandom;
                end
                7:
                begin
                    turn_val = 16'hFFFF;
                    fast_val = '0;
                    slow_val = 16'hFFFF;
                end
                default: ;
            endcase
            if (square_thr)
            begin
                far_val  = 48'(longint'(far_root) * longint'(far_root));
                near_val = 48'(longint'(near_root) * longint'(near_root));
            end

            // junk above bit 15 of the narrow registers must be dropped
            write_reg(REG_TURN_RATE, {$urandom, turn_val});
            write_reg(REG_FAR_DIST_SQ, far_val);
            write_reg(REG_NEAR_DIST_SQ, near_val);
            write_reg(REG_FAST_SPEED, {$urandom, fast_val});
            write_reg(REG_SLOW_SPEED, {$urandom, slow_val});
            write_reg(REG_SLOW_SPEED + 3'd1 + 3'($urandom_range(0, 2)),
                      48'({$urandom, $urandom}));
            wr_en <= 1'b0;

            pause_at = $urandom_range(20, PHASE_BEATS - 20);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                if (n == pause_at)
                    wait_results(0);
                send_frame(random_frame(), 1'b0, '0);
            end
            wait_results(TAIL_CYCLES);
        end

        $display("%0d frame beats sent, %0d result beats checked, %0d register settings",
                 accepted, checked, PHASES + 1);
        $display("covered threshold ties, wide distances, half-turn errors and idle gaps");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/rlps_pkg.sv
rtl/rlps_front.sv
rtl/rlps_cordic.sv
rtl/rlps_queue.sv
rtl/rlps_back.sv
rtl/rate_limited_pursuit_steering.sv
tb/rate_limited_pursuit_steering_tb.sv
